### rtl/cssl_pkg.sv
// shared constants, codes and the command record for the sparse store lookup unit
package cssl_pkg;

   localparam int MAX_ENTRIES = 1024;
   localparam int MAX_ROWS    = 64;
   localparam int MAX_COLS    = 64;

   localparam int ENTRY_AW    = $clog2(MAX_ENTRIES);
   localparam int COUNT_W     = ENTRY_AW + 1;
   localparam int ROW_AW      = $clog2(MAX_ROWS);
   localparam int COL_AW      = $clog2(MAX_COLS);
   localparam int SIZE_W      = 7;
   localparam int VALUE_W     = 32;
   localparam int OPCODE_W    = 2;
   localparam int STATUS_W    = 2;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_LOAD  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_QUERY = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_DONE   = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NO_ROW = 2'd3;

   localparam logic CSR_NUM_ROWS = 1'b0;
   localparam logic CSR_NUM_COLS = 1'b1;

   localparam logic [SIZE_W-1:0] NUM_ROWS_RESET = 7'd64;
   localparam logic [SIZE_W-1:0] NUM_COLS_RESET = 7'd64;

   // one classified item handed from the front to the back
   typedef struct packed {
      logic                store_en;
      logic                rowend_en;
      logic                scan_en;
      logic [ENTRY_AW-1:0] store_addr;
      logic [VALUE_W-1:0]  store_value;
      logic [COL_AW-1:0]   store_col;
      logic [ROW_AW-1:0]   row;
      logic [COL_AW-1:0]   query_col;
      logic [COUNT_W-1:0]  count;
      logic [STATUS_W-1:0] status;
   } cmd_type;

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] hi);
      logic [SIZE_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = SIZE_W'(1);
      end else if (v > hi) begin
         r = hi;
      end
      return r;
   endfunction

endpackage

### rtl/cssl_front.sv
// front end: configuration registers, load position tracking and item classification
module cssl_front import cssl_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_index,
   input  logic [SIZE_W-1:0]   csr_wdata,
   input  logic                push,
   input  logic [OPCODE_W-1:0] opcode,
   input  logic [VALUE_W-1:0]  element_value,
   input  logic [ROW_AW-1:0]   query_row,
   input  logic [COL_AW-1:0]   query_col,
   input  logic                q_full,
   output logic                q_push,
   output cmd_type             cmd
);

   logic [SIZE_W-1:0]  num_rows_ff, num_cols_ff;
   logic [SIZE_W-1:0]  load_row_ff, load_row_in;
   logic [COL_AW-1:0]  load_col_ff, load_col_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [SIZE_W-1:0]  rows_eff, cols_eff;
   logic               keep;
   logic               accept;

   assign csr_ready = 1'b1;
   assign accept    = push && !q_full;
   assign q_push    = accept;
   assign rows_eff  = clamp_size(num_rows_ff, SIZE_W'(MAX_ROWS));
   assign cols_eff  = clamp_size(num_cols_ff, SIZE_W'(MAX_COLS));

   // elements at even row and even column always count as zero
   assign keep = !(!load_row_ff[0] && !load_col_ff[0]) && (element_value != '0);

   always_comb begin
      load_row_in     = load_row_ff;
      load_col_in     = load_col_ff;
      count_in        = count_ff;
      cmd             = '0;
      cmd.store_addr  = count_ff[ENTRY_AW-1:0];
      cmd.store_value = element_value;
      cmd.store_col   = load_col_ff;
      cmd.row         = query_row;
      cmd.query_col   = query_col;
      cmd.status      = STATUS_OK;
      unique case (opcode)
         OP_CLEAR: begin
            load_row_in = '0;
            load_col_in = '0;
            count_in    = '0;
         end
         OP_LOAD: begin
            if (load_row_ff >= rows_eff) begin
               cmd.status = STATUS_DONE;
            end else begin
               if (keep) begin
                  if (count_ff == COUNT_W'(MAX_ENTRIES)) begin
                     cmd.status = STATUS_FULL;
                  end else begin
                     cmd.store_en = 1'b1;
                     count_in     = count_ff + COUNT_W'(1);
                  end
               end
               if ((SIZE_W'(load_col_ff) + SIZE_W'(1)) >= cols_eff) begin
                  cmd.rowend_en = 1'b1;
                  cmd.row       = load_row_ff[ROW_AW-1:0];
                  load_row_in   = load_row_ff + SIZE_W'(1);
                  load_col_in   = '0;
               end else begin
                  load_col_in = load_col_ff + COL_AW'(1);
               end
            end
         end
         OP_QUERY: begin
            if (SIZE_W'(query_row) >= load_row_ff) begin
               cmd.status = STATUS_NO_ROW;
            end else begin
               cmd.scan_en = 1'b1;
            end
         end
         default: begin
         end
      endcase
      cmd.count = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff <= NUM_ROWS_RESET;
         num_cols_ff <= NUM_COLS_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_NUM_ROWS) begin
            num_rows_ff <= csr_wdata;
         end
         if (csr_index == CSR_NUM_COLS) begin
            num_cols_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_row_ff <= '0;
         load_col_ff <= '0;
         count_ff    <= '0;
      end else if (accept) begin
         load_row_ff <= load_row_in;
         load_col_ff <= load_col_in;
         count_ff    <= count_in;
      end
   end

endmodule

### rtl/cssl_queue.sv
// short command queue between front and back
module cssl_queue import cssl_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_en,
   input  cmd_type wr_data,
   input  logic    rd_en,
   output cmd_type rd_data,
   output logic    full,
   output logic    empty
);

   cmd_type              slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_AW:0]    fill_ff;

   assign full    = (fill_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign empty   = (fill_ff == '0);
   assign rd_data = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (wr_en) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_AW'(1);
         end
         if (rd_en) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_AW'(1);
         end
         if (wr_en && !rd_en) begin
            fill_ff <= fill_ff + (QUEUE_AW+1)'(1);
         end else if (rd_en && !wr_en) begin
            fill_ff <= fill_ff - (QUEUE_AW+1)'(1);
         end
      end
   end

endmodule

### rtl/cssl_back.sv
// back end: entry and row-end stores, row scan and the result register
module cssl_back import cssl_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             head,
   input  logic                q_empty,
   output logic                q_pop,
   input  logic                pop,
   output logic                empty,
   output logic [VALUE_W-1:0]  read_value,
   output logic                found,
   output logic [COUNT_W-1:0]  entries_stored,
   output logic [STATUS_W-1:0] status
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_BOUNDS = 2'd1;
   localparam logic [1:0] ST_SCAN   = 2'd2;

   logic [VALUE_W-1:0] value_mem  [MAX_ENTRIES];
   logic [COL_AW-1:0]  col_mem    [MAX_ENTRIES];
   logic [COUNT_W-1:0] rowend_mem [MAX_ROWS];

   logic [1:0]          state_ff, state_in;
   logic [COL_AW-1:0]   qcol_ff;
   logic [COUNT_W-1:0]  qcount_ff;
   logic                row_zero_ff;
   logic [COUNT_W-1:0]  start_rd_ff, end_rd_ff;
   logic [COUNT_W-1:0]  idx_ff, end_ff;
   logic                rd_vld_ff;
   logic [VALUE_W-1:0]  rd_value_ff;
   logic [COL_AW-1:0]   rd_col_ff;
   logic                rsp_valid_ff;
   logic [VALUE_W-1:0]  rsp_value_ff;
   logic                rsp_found_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   logic out_free, hit, scan_done;
   logic take_query, take_other, issue, finish;

   assign out_free  = !rsp_valid_ff || pop;
   assign hit       = rd_vld_ff && (rd_col_ff == qcol_ff);
   assign scan_done = hit || (idx_ff >= end_ff);

   always_comb begin
      q_pop      = 1'b0;
      take_query = 1'b0;
      take_other = 1'b0;
      issue      = 1'b0;
      finish     = 1'b0;
      state_in   = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               if (head.scan_en) begin
                  q_pop      = 1'b1;
                  take_query = 1'b1;
                  state_in   = ST_BOUNDS;
               end else if (out_free) begin
                  q_pop      = 1'b1;
                  take_other = 1'b1;
               end
            end
         end
         ST_BOUNDS: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_done) begin
               if (out_free) begin
                  finish   = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               issue = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // entry stores: at most one write per load, one read per scan step
   always_ff @(posedge clock) begin
      if (take_other && head.store_en) begin
         value_mem[head.store_addr] <= head.store_value;
         col_mem[head.store_addr]   <= head.store_col;
      end
      if (issue) begin
         rd_value_ff <= value_mem[idx_ff[ENTRY_AW-1:0]];
         rd_col_ff   <= col_mem[idx_ff[ENTRY_AW-1:0]];
      end
   end

   // row ends: slot r holds the entry count at the end of row r
   always_ff @(posedge clock) begin
      if (take_other && head.rowend_en) begin
         rowend_mem[head.row] <= head.count;
      end
      if (take_query) begin
         end_rd_ff   <= rowend_mem[head.row];
         start_rd_ff <= rowend_mem[head.row - ROW_AW'(1)];
      end
   end

   always_ff @(posedge clock) begin
      if (take_query) begin
         qcol_ff     <= head.query_col;
         qcount_ff   <= head.count;
         row_zero_ff <= (head.row == '0);
      end
      if (state_ff == ST_BOUNDS) begin
         idx_ff <= row_zero_ff ? '0 : start_rd_ff;
         end_ff <= end_rd_ff;
      end else if (issue) begin
         idx_ff <= idx_ff + COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_BOUNDS) begin
            rd_vld_ff <= 1'b0;
         end else if (issue) begin
            rd_vld_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take_other || finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (pop) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take_other) begin
         rsp_value_ff  <= '0;
         rsp_found_ff  <= 1'b0;
         rsp_count_ff  <= head.count;
         rsp_status_ff <= head.status;
      end else if (finish) begin
         rsp_value_ff  <= hit ? rd_value_ff : '0;
         rsp_found_ff  <= hit;
         rsp_count_ff  <= qcount_ff;
         rsp_status_ff <= STATUS_OK;
      end
   end

   assign empty          = !rsp_valid_ff;
   assign read_value     = rsp_value_ff;
   assign found          = rsp_found_ff;
   assign entries_stored = rsp_count_ff;
   assign status         = rsp_status_ff;

`ifndef SYNTHESIS
   a_idx_in_row: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> idx_ff <= end_ff)
      else $error("scan index beyond row end");
   a_end_in_store: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> end_ff <= COUNT_W'(MAX_ENTRIES))
      else $error("row end beyond entry store");
   a_found_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_found_ff |-> rsp_value_ff != '0 && rsp_status_ff == STATUS_OK)
      else $error("found result carries zero value or bad status");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("command queue popped while empty");
   a_finish_lands: assert property (@(posedge clock) disable iff (reset)
      finish |=> state_ff == ST_IDLE && rsp_valid_ff)
      else $error("finished scan did not reach the result register");
`endif

endmodule

### rtl/csr_sparse_store_lookup_unit.sv
// top level of the compressed sparse row store with element lookup
//
//   channel   direction  handshake               payload
//   request   in         push / full             req_opcode, req_element_value,
//                                                req_query_row, req_query_col
//   response  out        empty / pop             rsp_read_value, rsp_found,
//                                                rsp_entries_stored, rsp_status
//   csr       in         csr_valid / csr_ready   csr_index, csr_wdata
//
// a clear, load or unused item is taken from the queue head once the back end is idle
//   and the result register is free; a query reads its row bounds, then scans the row
//   to a hit or its end via the entry store's single read port (one entry a cycle)
// the front accepts one item a cycle until the four-entry command queue fills
// reset is synchronous; the stores need no clearing, csr_ready is always high
// a waiting result stalls the back end only when it has another result to hand over
module csr_sparse_store_lookup_unit import cssl_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  logic [OPCODE_W-1:0] req_opcode,
   input  logic [VALUE_W-1:0]  req_element_value,
   input  logic [ROW_AW-1:0]   req_query_row,
   input  logic [COL_AW-1:0]   req_query_col,
   output logic                empty,
   input  logic                pop,
   output logic [VALUE_W-1:0]  rsp_read_value,
   output logic                rsp_found,
   output logic [COUNT_W-1:0]  rsp_entries_stored,
   output logic [STATUS_W-1:0] rsp_status,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_index,
   input  logic [SIZE_W-1:0]   csr_wdata
);

   cmd_type front_cmd, head_cmd;
   logic    q_push, q_pop, q_full, q_empty;

   assign full = q_full;

   cssl_front u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .push          (push),
      .opcode        (req_opcode),
      .element_value (req_element_value),
      .query_row     (req_query_row),
      .query_col     (req_query_col),
      .q_full        (q_full),
      .q_push        (q_push),
      .cmd           (front_cmd)
   );

   cssl_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_data (front_cmd),
      .rd_en   (q_pop),
      .rd_data (head_cmd),
      .full    (q_full),
      .empty   (q_empty)
   );

   cssl_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head_cmd),
      .q_empty        (q_empty),
      .q_pop          (q_pop),
      .pop            (pop),
      .empty          (empty),
      .read_value     (rsp_read_value),
      .found          (rsp_found),
      .entries_stored (rsp_entries_stored),
      .status         (rsp_status)
   );

endmodule
